// File: rtl/athm_pkg.sv
`default_nettype none

package athm_pkg;

  // Window depth and field widths
  localparam int WINDOW    = 16;
  localparam int ADC_W     = 12;
  localparam int TEMP_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Scaling: centidegrees = sum * 33000 / (4095 * count)
  localparam int ADC_FULL = 4095;
  localparam int SCALE    = 33000;

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * ADC_FULL + 1);
  localparam int NUM_W  = SUM_W + TEMP_W;
  localparam int DEN_W  = SUM_W;
  localparam int ITER_W = $clog2(NUM_W + 1);

  // Queue between intake and core
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_HOT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLD = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] HOT_RESET  = CFG_W'(2800);
  localparam logic [CFG_W-1:0] COLD_RESET = CFG_W'(2600);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_GO,
    ST_DIV,
    ST_DONE
  } core_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/athm_queue.sv
`default_nettype none

// Intake: small sample FIFO decoupling the input channel from the core.
module athm_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  input  wire logic [athm_pkg::ADC_W-1:0]  raw_sample,
  output logic                             q_valid,
  output logic [athm_pkg::ADC_W-1:0]       q_data,
  input  wire logic                        q_pop
);

  logic [athm_pkg::ADC_W-1:0]  slots [athm_pkg::QDEPTH];
  logic [athm_pkg::QPTR_W-1:0] wr_ptr;
  logic [athm_pkg::QPTR_W-1:0] rd_ptr;
  logic [athm_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign sample_ready = (count != athm_pkg::QCNT_W'(athm_pkg::QDEPTH));
  assign q_valid      = (count != '0);
  assign q_data       = slots[rd_ptr];
  assign push         = sample_valid && sample_ready;
  assign pop          = q_pop && q_valid;

  function automatic logic [athm_pkg::QPTR_W-1:0] bump(input logic [athm_pkg::QPTR_W-1:0] p);
    if (p == athm_pkg::QPTR_W'(athm_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= raw_sample;
    end
  end

endmodule

`default_nettype wire

// File: rtl/athm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module athm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [athm_pkg::NUM_W-1:0]  numer,
  input  wire logic [athm_pkg::DEN_W-1:0]  denom,
  output logic [athm_pkg::TEMP_W-1:0]      quot,
  output athm_pkg::div_stat_t              stat
);

  logic                        busy;
  logic                        done;
  logic [athm_pkg::ITER_W-1:0] iter;
  logic [athm_pkg::DEN_W-1:0]  rem;
  logic [athm_pkg::DEN_W-1:0]  den;
  logic [athm_pkg::NUM_W-1:0]  q;
  logic [athm_pkg::DEN_W:0]    trial;
  logic                        ge;

  assign trial = {rem, q[athm_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  assign quot      = q[athm_pkg::TEMP_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= athm_pkg::ITER_W'(athm_pkg::NUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == athm_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      rem <= ge ? athm_pkg::DEN_W'(trial - {1'b0, den}) : trial[athm_pkg::DEN_W-1:0];
      q   <= {q[athm_pkg::NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/athm_core.sv
`default_nettype none

// Back end: window ring, running sum, scaling, divide, hysteresis, result register.
module athm_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire logic [athm_pkg::ADC_W-1:0]     q_data,
  output logic                                q_pop,
  input  wire logic                           cfg_we,
  input  wire logic [athm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [athm_pkg::CFG_W-1:0]     cfg_data,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [athm_pkg::TEMP_W-1:0]         filtered_temp_centi,
  output logic                                heater_drive,
  output logic                                heater_switched
);

  athm_pkg::core_state_t state;
  athm_pkg::core_state_t state_next;

  logic [athm_pkg::ADC_W-1:0]  ring [athm_pkg::WINDOW];
  logic [athm_pkg::ADC_W-1:0]  old_sample;
  logic [athm_pkg::ADC_W-1:0]  sample;
  logic [athm_pkg::PTR_W-1:0]  wr_ptr;
  logic [athm_pkg::CNT_W-1:0]  fill_count;
  logic [athm_pkg::SUM_W-1:0]  sum;
  logic [athm_pkg::SUM_W-1:0]  sum_next;
  logic [athm_pkg::SUM_W:0]    sum_adj;
  logic                        full;
  logic [athm_pkg::NUM_W-1:0]  numer;
  logic [athm_pkg::DEN_W-1:0]  denom;
  logic [athm_pkg::CFG_W-1:0]  hot_threshold;
  logic [athm_pkg::CFG_W-1:0]  cold_threshold;
  logic                        heater_state;
  logic                        heater_next;
  logic                        div_start;
  logic                        load;
  logic [athm_pkg::TEMP_W-1:0] quot;
  athm_pkg::div_stat_t         div_stat;

  athm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .quot  (quot),
    .stat  (div_stat)
  );

  // Thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold  <= athm_pkg::HOT_RESET;
      cold_threshold <= athm_pkg::COLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == athm_pkg::REG_HOT) begin
        hot_threshold <= cfg_data;
      end else if (cfg_index == athm_pkg::REG_COLD) begin
        cold_threshold <= cfg_data;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= athm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      athm_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = athm_pkg::ST_SUM;
        end
      end
      athm_pkg::ST_SUM: begin
        state_next = athm_pkg::ST_MUL;
      end
      athm_pkg::ST_MUL: begin
        state_next = athm_pkg::ST_GO;
      end
      athm_pkg::ST_GO: begin
        div_start  = 1'b1;
        state_next = athm_pkg::ST_DIV;
      end
      athm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = athm_pkg::ST_DONE;
        end
      end
      athm_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = athm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = athm_pkg::ST_IDLE;
      end
    endcase
  end

  // Window bookkeeping
  assign full     = (fill_count == athm_pkg::CNT_W'(athm_pkg::WINDOW));
  assign sum_adj  = full ? ({1'b0, sum} - (athm_pkg::SUM_W + 1)'(old_sample)) : {1'b0, sum};
  assign sum_next = athm_pkg::SUM_W'(sum_adj + (athm_pkg::SUM_W + 1)'(sample));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      fill_count <= '0;
      sum        <= '0;
    end else if (state == athm_pkg::ST_SUM) begin
      sum <= sum_next;
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
      if (wr_ptr == athm_pkg::PTR_W'(athm_pkg::WINDOW - 1)) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  // Ring: read oldest entry on pop, overwrite it in the next cycle (ST_SUM)
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample     <= q_data;
      old_sample <= ring[wr_ptr];
    end
    if (state == athm_pkg::ST_SUM) begin
      ring[wr_ptr] <= sample;
    end
  end

  // Scale numerator and window divisor
  always_ff @(posedge clk) begin
    if (state == athm_pkg::ST_MUL) begin
      numer <= athm_pkg::NUM_W'(sum) * athm_pkg::NUM_W'(athm_pkg::SCALE);
      denom <= athm_pkg::DEN_W'(fill_count) * athm_pkg::DEN_W'(athm_pkg::ADC_FULL);
    end
  end

  // Hysteresis; hot test wins when thresholds cross
  always_comb begin
    if (quot > hot_threshold) begin
      heater_next = 1'b0;
    end else if (quot < cold_threshold) begin
      heater_next = 1'b1;
    end else begin
      heater_next = heater_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      heater_state <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        heater_state <= heater_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered_temp_centi <= quot;
      heater_switched     <= (heater_next != heater_state);
    end
  end

  assign heater_drive = heater_state;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= athm_pkg::CNT_W'(athm_pkg::WINDOW))
    else $error("fill count beyond window");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= athm_pkg::PTR_W'(athm_pkg::WINDOW - 1))
    else $error("write pointer beyond window");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == athm_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == athm_pkg::ST_DIV)
    else $error("divider running outside divide state");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == athm_pkg::ST_DONE))
    else $error("result loaded outside done state");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == athm_pkg::ST_SUM)
    else $error("pop not followed by sum update");
`endif

endmodule

`default_nettype wire

// File: rtl/averaged_hysteresis_thermostat_top.sv
`default_nettype none

// Channel   Signals                                          Dir  Handshake
// sample    raw_sample                                       in   sample_valid / sample_ready
// result    filtered_temp_centi, heater_drive, heater_switched out result_valid / result_ready
// config    cfg_index, cfg_data                              in   cfg_we, no wait
//
// One beat in gives one beat out. The core works on one sample at a time, in the
// steps pop, sum update, multiply, divider start, the bit-serial divide over the
// 32-bit scaled sum with its done flag, and result load.
// A two-beat sample queue takes samples while the core is busy, until it fills; the
// result register holds a finished beat while the core may pop the next sample.
// The core waits in its load step while the previous result beat is unaccepted.
// Synchronous active-high rst clears queue, window, sum and heater and reloads the reset thresholds.
// The sample ring needs no clearing: the fill count gates every use of it.
module averaged_hysteresis_thermostat_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire logic [athm_pkg::ADC_W-1:0]     raw_sample,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [athm_pkg::TEMP_W-1:0]         filtered_temp_centi,
  output logic                                heater_drive,
  output logic                                heater_switched,
  input  wire logic                           cfg_we,
  input  wire logic [athm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [athm_pkg::CFG_W-1:0]     cfg_data
);

  logic                       q_valid;
  logic [athm_pkg::ADC_W-1:0] q_data;
  logic                       q_pop;

  // Front: intake queue
  athm_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .raw_sample   (raw_sample),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  // Back: averaging, divide, hysteresis, result register
  athm_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .filtered_temp_centi (filtered_temp_centi),
    .heater_drive        (heater_drive),
    .heater_switched     (heater_switched)
  );

endmodule

`default_nettype wire

// File: tb/sv/averaged_hysteresis_thermostat_top_test.sv
module averaged_hysteresis_thermostat_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import athm_pkg::*;

  // Register slots past the map; writes there must leave both thresholds alone
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 185;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 400;       // long enough to back up the sample queue
  localparam int TIMEOUT_NS       = 6_000_000; // watchdog limit, several times a slow run

  // Idling profiles, percent of cycles
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_centi;
    logic              drive;
    logic              switched;
  } therm_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  logic [ADC_W-1:0]     raw_sample = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [TEMP_W-1:0]    filtered_temp_centi;
  logic                 heater_drive;
  logic                 heater_switched;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  averaged_hysteresis_thermostat_top u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .sample_valid        (sample_valid),
    .sample_ready        (sample_ready),
    .raw_sample          (raw_sample),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .filtered_temp_centi (filtered_temp_centi),
    .heater_drive        (heater_drive),
    .heater_switched     (heater_switched),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Thermostat prediction: own copy of the sample window, sum, heater and limits
  // ---------------------------------------------------------------------------
  logic [ADC_W-1:0]  hist_ring [WINDOW];
  int unsigned       hist_ptr  = 0;
  int unsigned       hist_fill = 0;
  int unsigned       hist_sum  = 0;
  logic              heat_model = 1'b0;
  logic [CFG_W-1:0]  hot_limit  = HOT_RESET;
  logic [CFG_W-1:0]  cold_limit = COLD_RESET;

  therm_result_t     expected_readings [$];
  logic [ADC_W-1:0]  sample_backlog [$];
  int                mismatch_count = 0;

  // Knobs the stimulus turns per phase; read by the clocked processes
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct     = 0;
  bit                rx_hold_req   = 1'b0;
  logic              rx_hold_active;
  int                rx_hold_left;

  // Slow sensor drift around the band between the limits
  int                drift_level = 0;
  int                drift_dir   = 1;
  int                band_center = 0;
  int                band_span   = 80;

  function automatic therm_result_t predict_reading(input logic [ADC_W-1:0] smp);
    longint unsigned avg;
    logic            was_on;
    therm_result_t   res;
    was_on = heat_model;
    // full window: oldest beat leaves the sum; warm-up: the window just grows
    if (hist_fill >= WINDOW)
      hist_sum = hist_sum - hist_ring[hist_ptr];
    else
      hist_fill = hist_fill + 1;
    hist_ring[hist_ptr] = smp;
    hist_sum = hist_sum + smp;
    hist_ptr = (hist_ptr + 1) % WINDOW;
    avg = (longint'(hist_sum) * SCALE) / (longint'(ADC_FULL) * hist_fill);
    // hot test first, so crossed limits turn the heater off
    if (avg > hot_limit)
      heat_model = 1'b0;
    else if (avg < cold_limit)
      heat_model = 1'b1;
    res.temp_centi = avg[TEMP_W-1:0];
    res.drive      = heat_model;
    res.switched   = (heat_model != was_on);
    return res;
  endfunction

  function automatic logic [ADC_W-1:0] next_sensor_sample();
    int pick;
    int v;
    pick = $urandom_range(99);
    // some pure noise and rail hits so every sample bit toggles
    if (pick < 2)
      return ($urandom_range(1) != 0) ? {ADC_W{1'b1}} : {ADC_W{1'b0}};
    if (pick < 10)
      return ADC_W'($urandom_range(4095));
    if ($urandom_range(39) == 0)
      drift_dir = -drift_dir;
    drift_level = drift_level + drift_dir * int'($urandom_range(30));
    if (drift_level > band_center + band_span) begin
      drift_level = band_center + band_span;
      drift_dir   = -1;
    end else if (drift_level < band_center - band_span) begin
      drift_level = band_center - band_span;
      drift_dir   = 1;
    end
    v = drift_level + int'($urandom_range(40)) - 20;
    if (v < 0)
      v = 0;
    else if (v > 4095)
      v = 4095;
    return ADC_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: offers beats from the backlog, predicts on each accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready)
        expected_readings.push_back(predict_reading(raw_sample));
      // valid stays up with a steady payload until the beat goes through
      if (!sample_valid || sample_ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_valid <= 1'b1;
          raw_sample   <= sample_backlog.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the stimulus only has to ask for it
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_active <= 1'b0;
      rx_hold_left   <= 0;
    end else if (rx_hold_active) begin
      rx_hold_left <= rx_hold_left - 1;
      if (rx_hold_left == 1)
        rx_hold_active <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_active <= 1'b1;
      rx_hold_left   <= LONG_HOLD_CYCLES;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    therm_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: unexpected result beat: temp %0d drive %0b switched %0b",
                   $time, filtered_temp_centi, heater_drive, heater_switched);
        end else begin
          want = expected_readings.pop_front();
          if (filtered_temp_centi !== want.temp_centi || heater_drive !== want.drive ||
              heater_switched !== want.switched) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: mismatch: exp temp %0d drive %0b sw %0b, got temp %0d drive %0b sw %0b",
                     $time, want.temp_centi, want.drive, want.switched,
                     filtered_temp_centi, heater_drive, heater_switched);
          end
        end
      end
      result_ready <= !rx_hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Everything sent has come back, then the core gets time to go quiet
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || sample_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_HOT:  hot_limit  = val;
      REG_COLD: cold_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] hot_val;
    logic [CFG_W-1:0] cold_val;
    int               lo;
    int               hi;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening run on the reset limits (hot 2800, cold 2600), no idling.
    // 347 lands between the limits; 347+348 averages to exactly 2800 (hold at
    // hot); adding 0 drops below cold (heater on); 596 brings the average to
    // exactly 2600 (hold at cold); 4095 goes hot (off). The rest finishes
    // warm-up with rail and alternating-bit values, then wraps the window so
    // the oldest entries start leaving the sum.
    sample_backlog = '{12'd347, 12'd348, 12'd0, 12'd596, 12'd4095,
                       12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd1, 12'd4094,
                       12'h800, 12'h7FF, 12'd0, 12'd0, 12'd4095,
                       12'd4095, 12'd4095, 12'd0, 12'h123, 12'hFED, 12'd2048};
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin             // hot out of reach, cold at zero: never switches
          hot_val  = 16'd33000;
          cold_val = 16'd0;
        end
        2: begin             // both at the top: always below cold
          hot_val  = 16'hFFFF;
          cold_val = 16'hFFFF;
        end
        4: begin             // both at zero: any warmth turns it off
          hot_val  = 16'd0;
          cold_val = 16'd0;
        end
        5: begin             // crossed limits, hot test wins
          hot_val  = CFG_W'($urandom_range(30000, 200));
          cold_val = hot_val + CFG_W'($urandom_range(2000, 1));
        end
        7: begin             // zero-width band
          hot_val  = CFG_W'($urandom_range(32000, 500));
          cold_val = hot_val;
        end
        default: begin       // ordinary hysteresis band
          cold_val = CFG_W'($urandom_range(30000, 500));
          hot_val  = cold_val + CFG_W'($urandom_range(3000));
        end
      endcase

      // spare indexes get junk that must be dropped
      write_reg(REG_UNUSED_2, CFG_W'($urandom));
      write_reg(REG_UNUSED_3, CFG_W'($urandom));
      write_reg(REG_HOT, hot_val);
      write_reg(REG_COLD, cold_val);

      // center the drift on the band, in ADC counts
      lo = (int'(hot_val) < int'(cold_val)) ? int'(hot_val) : int'(cold_val);
      hi = (int'(hot_val) < int'(cold_val)) ? int'(cold_val) : int'(hot_val);
      band_center = ((lo + hi) / 2) * ADC_FULL / SCALE;
      if (band_center > 4095)
        band_center = 4095;
      band_span = (hi - lo) * ADC_FULL / SCALE + 80;
      if (band_span > 2048)
        band_span = 2048;
      drift_level = band_center;

      @(negedge clk);
      case (idle_mode_t'(p % 4))
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 68;
          stall_pct     = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          stall_pct     = 68;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct     = 31;
        end
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        sample_backlog.push_back(next_sensor_sample());

      // one phase with the sender flat out while the receiver holds off,
      // so the queue fills and sample_ready drops
      if (p == 6) begin
        rx_hold_req = 1'b1;
        while (!rx_hold_active)
          @(negedge clk);
        rx_hold_req = 1'b0;
      end

      wait_drained();
    end

    if (mismatch_count == 0 && expected_readings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
